// File: rtl/mdfs_pkg.sv
// ----------------------------------------------------------------------------
// mdfs_pkg: shared definitions for the depth-first maze explorer
// Grid and stack sizes, command and direction codes, the result record and
// small helpers for goal and neighbor tests.
// ----------------------------------------------------------------------------
`default_nettype none

package mdfs_pkg;

  // Grid geometry
  localparam int GridSide = 16;
  localparam int CoordW   = 4;
  localparam int CellAw   = 2 * CoordW;
  localparam int SizeW    = 5;

  // Path stack
  localparam int StackDepth = 256;
  localparam int StackAw    = $clog2(StackDepth);
  localparam int StackCntW  = StackAw + 1;

  // Explored cell counter
  localparam int CountW   = 9;
  localparam int CountMax = 511;

  // Result queue
  localparam int ResultDepth = 4;
  localparam int ResultAw    = $clog2(ResultDepth);

  // Configuration register indexes
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegMazeWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegMazeHeight = 1'b1;

  // Command codes
  localparam logic [1:0] CmdIdle  = 2'd0;
  localparam logic [1:0] CmdRight = 2'd1;
  localparam logic [1:0] CmdLeft  = 2'd2;
  localparam logic [1:0] CmdFwd   = 2'd3;

  // Absolute directions, north is +y, east is +x
  localparam logic [1:0] DirN = 2'd0;
  localparam logic [1:0] DirE = 2'd1;
  localparam logic [1:0] DirS = 2'd2;
  localparam logic [1:0] DirW = 2'd3;

  typedef struct packed {
    logic [1:0]        command;
    logic              last_of_run;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [1:0]        heading;
    logic              goal_reached;
    logic              finished;
    logic [CountW-1:0] cells_explored;
  } result_t;

  // Size register limited to the grid side
  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v);
    logic [SizeW-1:0] side;
    side = SizeW'(GridSide);
    return (v > side) ? side : v;
  endfunction

  // One of the four central cells
  function automatic logic is_goal(input logic [CoordW-1:0] x,
                                   input logic [CoordW-1:0] y,
                                   input logic [SizeW-1:0]  w,
                                   input logic [SizeW-1:0]  h);
    logic [SizeW-1:0] cx;
    logic [SizeW-1:0] cy;
    logic [SizeW-1:0] xe;
    logic [SizeW-1:0] ye;
    logic             hx;
    logic             hy;
    cx = w >> 1;
    cy = h >> 1;
    xe = {1'b0, x};
    ye = {1'b0, y};
    hx = (xe == cx) || ((cx != '0) && (xe == cx - 5'd1));
    hy = (ye == cy) || ((cy != '0) && (ye == cy - 5'd1));
    return hx && hy;
  endfunction

  // Neighbor in direction d lies inside the configured area
  function automatic logic nb_in_grid(input logic [CoordW-1:0] x,
                                      input logic [CoordW-1:0] y,
                                      input logic [1:0]        d,
                                      input logic [SizeW-1:0]  w,
                                      input logic [SizeW-1:0]  h);
    logic [SizeW-1:0] xe;
    logic [SizeW-1:0] ye;
    logic             ok;
    xe = {1'b0, x};
    ye = {1'b0, y};
    case (d)
      DirN:    ok = (xe < w) && (ye + 5'd1 < h);
      DirE:    ok = (xe + 5'd1 < w) && (ye < h);
      DirS:    ok = (y != '0) && (xe < w) && (ye - 5'd1 < h);
      DirW:    ok = (x != '0) && (xe - 5'd1 < w) && (ye < h);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Map address of the neighbor in direction d (wraps at the grid edge)
  function automatic logic [CellAw-1:0] nb_addr(input logic [CoordW-1:0] x,
                                                input logic [CoordW-1:0] y,
                                                input logic [1:0]        d);
    logic [CoordW-1:0] nx;
    logic [CoordW-1:0] ny;
    nx = x;
    ny = y;
    case (d)
      DirN:    ny = y + 4'd1;
      DirE:    nx = x + 4'd1;
      DirS:    ny = y - 4'd1;
      DirW:    nx = x - 4'd1;
      default: nx = x;
    endcase
    return {ny, nx};
  endfunction

endpackage

`default_nettype wire

// File: rtl/maze_dfs_explorer.sv
// ----------------------------------------------------------------------------
// maze_dfs_explorer: depth-first micromouse maze explorer
// Takes one sensor item per control tick and emits turn and forward commands
// from a wall/visited map and a path stack held in synchronous memories.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid_i/in_ready_o  | wall_front/left/right
//  out     | output    | out_valid_o/out_ready_i| command .. cells_explored
//  cfg     | input     | cfg_we_i (no wait)     | cfg_idx_i, cfg_wdata_i
//
//  A commit tick moves and emits an idle; a finished tick emits an idle.
//  An exploring tick reads the current cell, then each neighbor tried (up to
//  four), the path stack on a backtrack, and emits each command in turn.
//  The single read port of the cell map puts these reads in sequence.
//  An input buffer takes the next item while the current one is worked on,
//  and a 4-entry result queue lets output stalls overlap the work.
//  Reset clears the map through per-cell valid bits; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module maze_dfs_explorer (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration
  input  wire logic                               cfg_we_i,
  input  wire logic [mdfs_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [mdfs_pkg::SizeW-1:0]         cfg_wdata_i,
  // sensor items
  input  wire logic                               in_valid_i,
  output      logic                               in_ready_o,
  input  wire logic                               wall_front_i,
  input  wire logic                               wall_left_i,
  input  wire logic                               wall_right_i,
  // command items
  output      logic                               out_valid_o,
  input  wire logic                               out_ready_i,
  output      logic [1:0]                         command_o,
  output      logic                               last_of_run_o,
  output      logic [mdfs_pkg::CoordW-1:0]        pos_x_o,
  output      logic [mdfs_pkg::CoordW-1:0]        pos_y_o,
  output      logic [1:0]                         heading_o,
  output      logic                               goal_reached_o,
  output      logic                               finished_o,
  output      logic [mdfs_pkg::CountW-1:0]        cells_explored_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRdCur = 3'd1;
  localparam logic [2:0] StNb    = 3'd2;
  localparam logic [2:0] StPop   = 3'd3;
  localparam logic [2:0] StTurn  = 3'd4;
  localparam logic [2:0] StEmit  = 3'd5;

  localparam int CW  = mdfs_pkg::CoordW;
  localparam int AW  = mdfs_pkg::CellAw;
  localparam int SW  = mdfs_pkg::StackAw;
  localparam int SCW = mdfs_pkg::StackCntW;
  localparam int NW  = mdfs_pkg::CountW;
  localparam int RD  = mdfs_pkg::ResultDepth;
  localparam int RAW = mdfs_pkg::ResultAw;
  localparam int Cells = 1 << AW;

  // Configuration registers
  logic [mdfs_pkg::SizeW-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mdfs_pkg::SizeW'(mdfs_pkg::GridSide);
      height_q <= mdfs_pkg::SizeW'(mdfs_pkg::GridSide);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mdfs_pkg::RegMazeWidth:  width_q  <= cfg_wdata_i;
        mdfs_pkg::RegMazeHeight: height_q <= cfg_wdata_i;
        default:                 width_q  <= width_q;
      endcase
    end
  end

  logic [mdfs_pkg::SizeW-1:0] w_c, h_c;
  assign w_c = mdfs_pkg::clamp_size(width_q);
  assign h_c = mdfs_pkg::clamp_size(height_q);

  // Input buffer: front, left, right
  logic       in_full_q, in_full_d;
  logic [2:0] in_walls_q;
  logic       in_take;

  assign in_ready_o = !in_full_q;

  always_comb begin
    in_full_d = in_full_q;
    if (in_take) begin
      in_full_d = 1'b0;
    end else if (in_valid_i && !in_full_q) begin
      in_full_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else begin
      in_full_q <= in_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_full_q) begin
      in_walls_q <= {wall_front_i, wall_left_i, wall_right_i};
    end
  end

  // Cell map memory: {visited, walls N/E/S/W by bit}
  logic [4:0]    cell_mem [Cells];
  logic [Cells-1:0] cell_vld_q;
  logic [4:0]    cell_rdata_q;
  logic          cell_rvld_q;
  logic          cell_re, cell_we;
  logic [AW-1:0] cell_raddr, cell_waddr;
  logic [4:0]    cell_wdata;
  logic [4:0]    cell_data;

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    if (cell_re) begin
      cell_rdata_q <= cell_mem[cell_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_vld_q  <= '0;
      cell_rvld_q <= 1'b0;
    end else begin
      if (cell_we) begin
        cell_vld_q[cell_waddr] <= 1'b1;
      end
      if (cell_re) begin
        cell_rvld_q <= cell_vld_q[cell_raddr];
      end
    end
  end

  // never-written cells read as zero
  assign cell_data = cell_rvld_q ? cell_rdata_q : 5'd0;

  // Path stack memory; entry zero is the start cell and never written
  logic [AW-1:0] stk_mem [mdfs_pkg::StackDepth];
  logic [AW-1:0] stk_rdata_q;
  logic          stk_rzero_q;
  logic          stk_re, stk_we;
  logic [SW-1:0] stk_raddr, stk_waddr;
  logic [AW-1:0] stk_wdata;
  logic [AW-1:0] stk_data;

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata_q <= stk_mem[stk_raddr];
      stk_rzero_q <= (stk_raddr == '0);
    end
  end

  assign stk_data = stk_rzero_q ? '0 : stk_rdata_q;

  // Result queue
  mdfs_pkg::result_t res_q [RD];
  logic [RAW-1:0]    rptr_q, wptr_q;
  logic [RAW:0]      rcnt_q;
  logic              res_push, res_pop;
  mdfs_pkg::result_t res_wdata;

  assign res_pop     = out_valid_o && out_ready_i;
  assign out_valid_o = (rcnt_q != '0);

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_q[wptr_q] <= res_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rptr_q <= '0;
      wptr_q <= '0;
      rcnt_q <= '0;
    end else begin
      if (res_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (res_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      case ({res_push, res_pop})
        2'b10:   rcnt_q <= rcnt_q + 1'b1;
        2'b01:   rcnt_q <= rcnt_q - 1'b1;
        default: rcnt_q <= rcnt_q;
      endcase
    end
  end

  assign command_o        = res_q[rptr_q].command;
  assign last_of_run_o    = res_q[rptr_q].last_of_run;
  assign pos_x_o          = res_q[rptr_q].pos_x;
  assign pos_y_o          = res_q[rptr_q].pos_y;
  assign heading_o        = res_q[rptr_q].heading;
  assign goal_reached_o   = res_q[rptr_q].goal_reached;
  assign finished_o       = res_q[rptr_q].finished;
  assign cells_explored_o = res_q[rptr_q].cells_explored;

  // Explorer state
  logic [2:0]     state_q, state_d;
  logic [CW-1:0]  cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [1:0]     facing_q, facing_d;
  logic [SCW-1:0] stk_cnt_q, stk_cnt_d;
  logic           pend_q, pend_d;
  logic [1:0]     pend_dir_q, pend_dir_d;
  logic           pend_back_q, pend_back_d;
  logic           goal_q, goal_d;
  logic           done_q, done_d;
  logic [NW-1:0]  explored_q, explored_d;
  logic [2:0]     sense_q, sense_d;
  logic [3:0]     walls_q, walls_d;
  logic [1:0]     nb_q, nb_d;
  logic [1:0]     target_q, target_d;
  logic           back_q, back_d;

  // sensed walls in absolute directions
  logic [1:0] left_dir, right_dir;
  logic [3:0] sensed;

  assign left_dir  = facing_q + 2'd3;
  assign right_dir = facing_q + 2'd1;

  always_comb begin
    sensed = '0;
    if (sense_q[2]) sensed[facing_q]  = 1'b1;
    if (sense_q[1]) sensed[left_dir]  = 1'b1;
    if (sense_q[0]) sensed[right_dir] = 1'b1;
  end

  // backtrack target: direction from the current cell to the popped cell
  logic [CW-1:0] pop_x, pop_y;
  logic          pop_hit;
  logic [1:0]    pop_dir;

  assign pop_x = stk_data[CW-1:0];
  assign pop_y = stk_data[AW-1:CW];

  always_comb begin
    pop_hit = 1'b1;
    pop_dir = mdfs_pkg::DirN;
    if (pop_x == cur_x_q && cur_y_q != '1 && pop_y == cur_y_q + 4'd1) begin
      pop_dir = mdfs_pkg::DirN;
    end else if (cur_x_q != '1 && pop_x == cur_x_q + 4'd1 && pop_y == cur_y_q) begin
      pop_dir = mdfs_pkg::DirE;
    end else if (cur_y_q != '0 && pop_x == cur_x_q && pop_y == cur_y_q - 4'd1) begin
      pop_dir = mdfs_pkg::DirS;
    end else if (cur_x_q != '0 && pop_x == cur_x_q - 4'd1 && pop_y == cur_y_q) begin
      pop_dir = mdfs_pkg::DirW;
    end else begin
      pop_hit = 1'b0;
    end
  end

  // commit target and open-neighbor test
  logic          commit_ok;
  logic [CW-1:0] commit_x, commit_y;
  logic          nb_ok;
  logic [3:0]    new_walls;
  logic [1:0]    turn_diff;

  always_comb begin
    commit_x  = cur_x_q;
    commit_y  = cur_y_q;
    commit_ok = 1'b1;
    case (pend_dir_q)
      mdfs_pkg::DirN: begin
        commit_ok = (cur_y_q != '1);
        commit_y  = cur_y_q + 4'd1;
      end
      mdfs_pkg::DirE: begin
        commit_ok = (cur_x_q != '1);
        commit_x  = cur_x_q + 4'd1;
      end
      mdfs_pkg::DirS: begin
        commit_ok = (cur_y_q != '0);
        commit_y  = cur_y_q - 4'd1;
      end
      default: begin
        commit_ok = (cur_x_q != '0);
        commit_x  = cur_x_q - 4'd1;
      end
    endcase
  end

  assign nb_ok = mdfs_pkg::nb_in_grid(cur_x_q, cur_y_q, nb_q, w_c, h_c) &&
                 !cell_data[4] && !walls_q[nb_q];
  assign new_walls = cell_data[3:0] | sensed;
  assign turn_diff = target_q - facing_q;

  // Sequencer: read, modify and write back the maps
  always_comb begin
    state_d     = state_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    facing_d    = facing_q;
    stk_cnt_d   = stk_cnt_q;
    pend_d      = pend_q;
    pend_dir_d  = pend_dir_q;
    pend_back_d = pend_back_q;
    goal_d      = goal_q;
    done_d      = done_q;
    explored_d  = explored_q;
    sense_d     = sense_q;
    walls_d     = walls_q;
    nb_d        = nb_q;
    target_d    = target_q;
    back_d      = back_q;

    in_take    = 1'b0;
    cell_re    = 1'b0;
    cell_raddr = {cur_y_q, cur_x_q};
    cell_we    = 1'b0;
    cell_waddr = {cur_y_q, cur_x_q};
    cell_wdata = {1'b1, new_walls};
    stk_re     = 1'b0;
    stk_raddr  = SW'(stk_cnt_q - SCW'(2));
    stk_we     = 1'b0;
    stk_waddr  = stk_cnt_q[SW-1:0];
    stk_wdata  = {commit_y, commit_x};

    res_push                 = 1'b0;
    res_wdata.command        = mdfs_pkg::CmdIdle;
    res_wdata.last_of_run    = 1'b1;
    res_wdata.pos_x          = cur_x_q;
    res_wdata.pos_y          = cur_y_q;
    res_wdata.heading        = facing_q;
    res_wdata.goal_reached   = goal_q;
    res_wdata.finished       = done_q;
    res_wdata.cells_explored = explored_q;

    unique case (state_q)
      StIdle: begin
        // start only with room for a full run of three results
        if (in_full_q && rcnt_q <= (RAW+1)'(RD - 3)) begin
          in_take = 1'b1;
          sense_d = in_walls_q;
          if (pend_q) begin
            // commit tick: move, and push unless backtracking or the stack is full
            if (commit_ok) begin
              cur_x_d = commit_x;
              cur_y_d = commit_y;
              if (!pend_back_q && stk_cnt_q < SCW'(mdfs_pkg::StackDepth)) begin
                stk_we    = 1'b1;
                stk_cnt_d = stk_cnt_q + 1'b1;
              end
            end
            pend_d      = 1'b0;
            pend_dir_d  = mdfs_pkg::DirN;
            pend_back_d = 1'b0;
            state_d     = StEmit;
          end else if (done_q) begin
            state_d = StEmit;
          end else begin
            cell_re = 1'b1;
            state_d = StRdCur;
          end
        end
      end
      StRdCur: begin
        // mark visited, merge walls, test for goal
        cell_we = 1'b1;
        walls_d = new_walls;
        if (explored_q != NW'(mdfs_pkg::CountMax)) begin
          explored_d = explored_q + 1'b1;
        end
        if (!goal_q && mdfs_pkg::is_goal(cur_x_q, cur_y_q, w_c, h_c)) begin
          goal_d  = 1'b1;
          done_d  = 1'b1;
          state_d = StEmit;
        end else begin
          cell_re    = 1'b1;
          cell_raddr = mdfs_pkg::nb_addr(cur_x_q, cur_y_q, mdfs_pkg::DirN);
          nb_d       = mdfs_pkg::DirN;
          state_d    = StNb;
        end
      end
      StNb: begin
        // neighbors in order N, E, S, W
        if (nb_ok) begin
          target_d = nb_q;
          back_d   = 1'b0;
          state_d  = StTurn;
        end else if (nb_q == mdfs_pkg::DirW) begin
          if (stk_cnt_q > SCW'(1)) begin
            stk_re    = 1'b1;
            stk_cnt_d = stk_cnt_q - 1'b1;
            state_d   = StPop;
          end else begin
            done_d  = 1'b1;
            state_d = StEmit;
          end
        end else begin
          nb_d       = nb_q + 2'd1;
          cell_re    = 1'b1;
          cell_raddr = mdfs_pkg::nb_addr(cur_x_q, cur_y_q, nb_q + 2'd1);
        end
      end
      StPop: begin
        if (pop_hit) begin
          target_d = pop_dir;
          back_d   = 1'b1;
          state_d  = StTurn;
        end else begin
          done_d  = 1'b1;
          state_d = StEmit;
        end
      end
      StTurn: begin
        // one turn a cycle, then forward
        res_push = 1'b1;
        if (facing_q != target_q) begin
          if (turn_diff == 2'd3) begin
            facing_d          = facing_q - 2'd1;
            res_wdata.command = mdfs_pkg::CmdLeft;
          end else begin
            facing_d          = facing_q + 2'd1;
            res_wdata.command = mdfs_pkg::CmdRight;
          end
          res_wdata.last_of_run = 1'b0;
          res_wdata.heading     = facing_d;
        end else begin
          res_wdata.command = mdfs_pkg::CmdFwd;
          pend_d      = 1'b1;
          pend_dir_d  = target_q;
          pend_back_d = back_q;
          state_d     = StIdle;
        end
      end
      StEmit: begin
        // single idle with the updated state
        res_push = 1'b1;
        state_d  = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      facing_q    <= mdfs_pkg::DirN;
      stk_cnt_q   <= SCW'(1);
      pend_q      <= 1'b0;
      pend_dir_q  <= mdfs_pkg::DirN;
      pend_back_q <= 1'b0;
      goal_q      <= 1'b0;
      done_q      <= 1'b0;
      explored_q  <= '0;
    end else begin
      state_q     <= state_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      facing_q    <= facing_d;
      stk_cnt_q   <= stk_cnt_d;
      pend_q      <= pend_d;
      pend_dir_q  <= pend_dir_d;
      pend_back_q <= pend_back_d;
      goal_q      <= goal_d;
      done_q      <= done_d;
      explored_q  <= explored_d;
    end
  end

  // per-item working registers
  always_ff @(posedge clk_i) begin
    sense_q  <= sense_d;
    walls_q  <= walls_d;
    nb_q     <= nb_d;
    target_q <= target_d;
    back_q   <= back_d;
  end

endmodule

`default_nettype wire

// File: rtl/mdfs_checker.sv
// ----------------------------------------------------------------------------
// mdfs_checker: port-level checks for the maze explorer
// Watches the command channel for stall behavior, run framing, goal implying
// finished and the finished state staying final.
// ----------------------------------------------------------------------------
`default_nettype none

module mdfs_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [1:0] command_o,
  input wire logic       last_of_run_o,
  input wire logic       goal_reached_o,
  input wire logic       finished_o
);

  // set once a finished item has been taken
  logic seen_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_done_q <= 1'b0;
    end else if (out_valid_o && out_ready_i && finished_o) begin
      seen_done_q <= 1'b1;
    end
  end

  // stalled item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(command_o) && $stable(last_of_run_o))
    else $error("stalled command item changed");

  // reaching the goal ends exploration
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && goal_reached_o |-> finished_o)
    else $error("goal reached without finished");

  // forward always closes a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_o == mdfs_pkg::CmdFwd |-> last_of_run_o)
    else $error("forward command not last of run");

  // after finishing only single idles follow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_done_q |->
      finished_o && last_of_run_o && command_o == mdfs_pkg::CmdIdle)
    else $error("activity after exploration finished");

endmodule

bind maze_dfs_explorer mdfs_checker u_mdfs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .command_o      (command_o),
  .last_of_run_o  (last_of_run_o),
  .goal_reached_o (goal_reached_o),
  .finished_o     (finished_o)
);

`default_nettype wire

// File: tb/maze_cmd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_cmd_checker: command stream checker for maze_dfs_explorer
// Watches the config port and both item channels, predicts the commands of
// every accepted sensor item from its own copy of the explorer state, and
// compares each accepted command item field by field with the oldest one due.
// ----------------------------------------------------------------------------
module maze_cmd_checker
  import mdfs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [SizeW-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                wall_front_i,
  input  logic                wall_left_i,
  input  logic                wall_right_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [1:0]          command_i,
  input  logic                last_of_run_i,
  input  logic [CoordW-1:0]   pos_x_i,
  input  logic [CoordW-1:0]   pos_y_i,
  input  logic [1:0]          heading_i,
  input  logic                goal_reached_i,
  input  logic                finished_i,
  input  logic [CountW-1:0]   cells_explored_i,
  output int                  waiting_o,
  output int                  fail_count_o
);

  // Explorer state as predicted
  logic [SizeW-1:0]  maze_w;
  logic [SizeW-1:0]  maze_h;
  logic [CoordW-1:0] mouse_x;
  logic [CoordW-1:0] mouse_y;
  logic [1:0]        facing;
  logic [3:0]        wall_bits  [GridSide*GridSide];
  logic              seen       [GridSide*GridSide];
  logic [CellAw-1:0] path_cells [StackDepth];
  int                path_len;
  logic              move_armed;
  logic [1:0]        move_dir;
  logic              move_back;
  logic              goal_hit;
  logic              run_over;
  logic [CountW-1:0] explored;

  result_t cmds_due [$];
  int      mismatches = 0;

  function automatic int step_col(input logic [1:0] d);
    case (d)
      DirE:    return 1;
      DirW:    return -1;
      default: return 0;
    endcase
  endfunction

  function automatic int step_row(input logic [1:0] d);
    case (d)
      DirN:    return 1;
      DirS:    return -1;
      default: return 0;
    endcase
  endfunction

  // One of the four central cells of a w by h area
  function automatic logic at_center(input int x, input int y, input int w, input int h);
    return (x == w / 2 - 1 || x == w / 2) && (y == h / 2 - 1 || y == h / 2);
  endfunction

  task automatic clear_state();
    maze_w     = SizeW'(GridSide);
    maze_h     = SizeW'(GridSide);
    mouse_x    = '0;
    mouse_y    = '0;
    facing     = DirN;
    for (int i = 0; i < GridSide * GridSide; i++) begin
      wall_bits[i] = '0;
      seen[i]      = 1'b0;
    end
    for (int i = 0; i < StackDepth; i++) path_cells[i] = '0;
    path_len   = 1;
    move_armed = 1'b0;
    move_dir   = DirN;
    move_back  = 1'b0;
    goal_hit   = 1'b0;
    run_over   = 1'b0;
    explored   = '0;
    cmds_due.delete();
  endtask

  task automatic queue_cmd(input logic [1:0] cmd, input logic last);
    result_t r;
    r.command        = cmd;
    r.last_of_run    = last;
    r.pos_x          = mouse_x;
    r.pos_y          = mouse_y;
    r.heading        = facing;
    r.goal_reached   = goal_hit;
    r.finished       = run_over;
    r.cells_explored = explored;
    cmds_due.push_back(r);
  endtask

  // Commands caused by one sensor item
  task automatic plan_moves(input logic wf, input logic wl, input logic wr);
    int               w;
    int               h;
    int               cx;
    int               cy;
    int               nx;
    int               ny;
    int               px;
    int               py;
    int               target;
    logic             back;
    logic [1:0]       d;
    logic [1:0]       diff;
    logic [CellAw-1:0] here_cell;
    logic [CellAw-1:0] prev;
    w      = (maze_w > GridSide) ? GridSide : int'(maze_w);
    h      = (maze_h > GridSide) ? GridSide : int'(maze_h);
    cx     = int'(mouse_x);
    cy     = int'(mouse_y);
    target = -1;
    back   = 1'b0;

    // tick after a forward: commit the move only
    if (move_armed) begin
      nx = cx + step_col(move_dir);
      ny = cy + step_row(move_dir);
      if (nx >= 0 && nx < GridSide && ny >= 0 && ny < GridSide) begin
        mouse_x = nx[CoordW-1:0];
        mouse_y = ny[CoordW-1:0];
        if (!move_back && path_len < StackDepth) begin
          path_cells[path_len] = {mouse_y, mouse_x};
          path_len++;
        end
      end
      move_armed = 1'b0;
      move_dir   = DirN;
      move_back  = 1'b0;
      queue_cmd(CmdIdle, 1'b1);
      return;
    end

    if (run_over) begin
      queue_cmd(CmdIdle, 1'b1);
      return;
    end

    // record the cell
    here_cell       = {mouse_y, mouse_x};
    seen[here_cell] = 1'b1;
    if (explored < CountMax) explored++;
    if (wf) wall_bits[here_cell][facing] = 1'b1;
    d = facing - 2'd1;
    if (wl) wall_bits[here_cell][d] = 1'b1;
    d = facing + 2'd1;
    if (wr) wall_bits[here_cell][d] = 1'b1;

    if (!goal_hit && at_center(cx, cy, w, h)) begin
      goal_hit = 1'b1;
      run_over = 1'b1;
      queue_cmd(CmdIdle, 1'b1);
      return;
    end

    // first open unvisited neighbor, N E S W
    for (int k = 0; k < 4; k++) begin
      d  = k[1:0];
      nx = cx + step_col(d);
      ny = cy + step_row(d);
      if (target < 0 && nx >= 0 && nx < w && ny >= 0 && ny < h &&
          !seen[{ny[CoordW-1:0], nx[CoordW-1:0]}] && !wall_bits[here_cell][d])
        target = k;
    end

    // dead end: pop and head back
    if (target < 0 && path_len > 1) begin
      prev = path_cells[path_len-2];
      px   = int'(prev[CoordW-1:0]);
      py   = int'(prev[CellAw-1:CoordW]);
      path_len--;
      for (int k = 0; k < 4; k++) begin
        d = k[1:0];
        if (target < 0 && cx + step_col(d) == px && cy + step_row(d) == py) begin
          target = k;
          back   = 1'b1;
        end
      end
    end

    if (target < 0) begin
      run_over = 1'b1;
      queue_cmd(CmdIdle, 1'b1);
      return;
    end

    // turns, a half turn as two rights, then forward
    d = target[1:0];
    while (facing != d) begin
      diff = d - facing;
      if (diff == 2'd3) begin
        facing = facing - 2'd1;
        queue_cmd(CmdLeft, 1'b0);
      end else begin
        facing = facing + 2'd1;
        queue_cmd(CmdRight, 1'b0);
      end
    end
    move_armed = 1'b1;
    move_dir   = d;
    move_back  = back;
    queue_cmd(CmdFwd, 1'b1);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_cmd();
    result_t want;
    if (cmds_due.size() == 0) begin
      $error("command item with none due: command %0d", command_i);
      mismatches++;
      return;
    end
    want = cmds_due.pop_front();
    check_field("command", 16'(want.command), 16'(command_i));
    check_field("last_of_run", 16'(want.last_of_run), 16'(last_of_run_i));
    check_field("pos_x", 16'(want.pos_x), 16'(pos_x_i));
    check_field("pos_y", 16'(want.pos_y), 16'(pos_y_i));
    check_field("heading", 16'(want.heading), 16'(heading_i));
    check_field("goal_reached", 16'(want.goal_reached), 16'(goal_reached_i));
    check_field("finished", 16'(want.finished), 16'(finished_i));
    check_field("cells_explored", 16'(want.cells_explored), 16'(cells_explored_i));
  endtask

  // Compare before predicting: an item's commands never leave on its own edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      waiting_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) compare_cmd();
      if (cfg_we_i) begin
        if (cfg_idx_i == RegMazeWidth) maze_w = cfg_wdata_i;
        else if (cfg_idx_i == RegMazeHeight) maze_h = cfg_wdata_i;
      end
      if (in_valid_i && in_ready_i) plan_moves(wall_front_i, wall_left_i, wall_right_i);
      waiting_o    <= cmds_due.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for maze_dfs_explorer
// Feeds a short hand-built walk through all sensor patterns, then random
// sensor items over several maze sizes (clamped, zero, odd, one wide), with
// random idling on both channels, one long output hold-off and a final push
// to the end of exploration. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import mdfs_pkg::*;

  // walk through the corner cells, sensors as {front, left, right}
  localparam logic [47:0] WalkSeq = {3'b000, 3'b111, 3'b111, 3'b000,
                                     3'b001, 3'b010, 3'b010, 3'b101,
                                     3'b100, 3'b110, 3'b011, 3'b000,
                                     3'b101, 3'b011, 3'b110, 3'b100};
  localparam int WalkLen = 16;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i    = RegMazeWidth;
  logic [SizeW-1:0]    cfg_wdata_i  = '0;
  logic                in_valid_i   = 1'b0;
  logic                wall_front_i = 1'b0;
  logic                wall_left_i  = 1'b0;
  logic                wall_right_i = 1'b0;
  logic                out_ready_i  = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic [1:0]          command_o;
  logic                last_of_run_o;
  logic [CoordW-1:0]   pos_x_o;
  logic [CoordW-1:0]   pos_y_o;
  logic [1:0]          heading_o;
  logic                goal_reached_o;
  logic                finished_o;
  logic [CountW-1:0]   cells_explored_o;

  int   cmds_waiting;
  int   fail_count;
  logic squeeze_req = 1'b0;
  logic sender_gaps = 1'b1;

  always #5 clk_i = ~clk_i;

  maze_dfs_explorer u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .wall_front_i     (wall_front_i),
    .wall_left_i      (wall_left_i),
    .wall_right_i     (wall_right_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .command_o        (command_o),
    .last_of_run_o    (last_of_run_o),
    .pos_x_o          (pos_x_o),
    .pos_y_o          (pos_y_o),
    .heading_o        (heading_o),
    .goal_reached_o   (goal_reached_o),
    .finished_o       (finished_o),
    .cells_explored_o (cells_explored_o)
  );

  maze_cmd_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .wall_front_i     (wall_front_i),
    .wall_left_i      (wall_left_i),
    .wall_right_i     (wall_right_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .command_i        (command_o),
    .last_of_run_i    (last_of_run_o),
    .pos_x_i          (pos_x_o),
    .pos_y_i          (pos_y_o),
    .heading_i        (heading_o),
    .goal_reached_i   (goal_reached_o),
    .finished_i       (finished_o),
    .cells_explored_i (cells_explored_o),
    .waiting_o        (cmds_waiting),
    .fail_count_o     (fail_count)
  );

  // Offer one sensor item, with random idle cycles ahead of it
  task automatic offer_sensors(input logic [2:0] s);
    while (sender_gaps && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    wall_front_i <= s[2];
    wall_left_i  <= s[1];
    wall_right_i <= s[0];
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Mostly sparse walls, now and then a dead end
  task automatic explore_random(input int n);
    logic [2:0] s;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) s = 3'b111;
      else s = {$urandom_range(99) < 30, $urandom_range(99) < 30, $urandom_range(99) < 30};
      offer_sensors(s);
    end
  endtask

  task automatic drain_cmds();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (cmds_waiting != 0);
  endtask

  task automatic set_size(input logic [SizeW-1:0] w, input logic [SizeW-1:0] h);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= RegMazeWidth;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_idx_i   <= RegMazeHeight;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Receiver: random stalls, one long hold-off when asked, then a clean stretch
  initial begin
    int   hold_left;
    int   open_left;
    logic squeezed;
    hold_left = 0;
    open_left = 0;
    squeezed  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (squeeze_req && !squeezed) begin
        squeezed  = 1'b1;
        hold_left = 300;
        open_left = 800;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (open_left > 0) begin
        open_left--;
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 24);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int sent;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // hand-built walk at the reset size
    for (int i = 0; i < WalkLen; i++) offer_sensors(WalkSeq[47-3*i -: 3]);

    // oversized registers clamp to the full grid
    drain_cmds();
    set_size(5'd31, 5'd31);
    explore_random(140);

    // zero size: no neighbor in range, forces a backtrack
    drain_cmds();
    set_size(5'd0, 5'd0);
    explore_random(3);

    // full grid, output held off while items keep coming
    drain_cmds();
    set_size(5'd16, 5'd16);
    squeeze_req <= 1'b1;
    sender_gaps = 1'b0;
    explore_random(80);
    sender_gaps = 1'b1;
    explore_random(60);

    // one column wide
    drain_cmds();
    set_size(5'd1, 5'd16);
    explore_random(4);

    // odd sizes
    drain_cmds();
    set_size(5'd9, 5'd7);
    explore_random(100);

    // single cell: walk back to the start until the run ends, then idle ticks
    drain_cmds();
    set_size(5'd1, 5'd1);
    sent = 0;
    while (finished_o !== 1'b1 && sent < 150) begin
      explore_random(1);
      sent++;
    end
    explore_random(10);

    drain_cmds();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** maze_dfs_explorer: PASSED **");
    end else begin
      $display("** maze_dfs_explorer: FAILED **");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("** maze_dfs_explorer: FAILED **");
    $finish;
  end

endmodule

// File: sim.f
rtl/mdfs_pkg.sv
rtl/maze_dfs_explorer.sv
rtl/mdfs_checker.sv
tb/maze_cmd_checker.sv
tb/tb.sv
